/* hw/rtl/code_lock_stepper_door_controller_assert.svh */
// Assertion macros used by the checker file of the code lock block.
// Depends on nothing; files that use it supply i_clk and i_rst_n.
`ifndef CODE_LOCK_STEPPER_DOOR_CONTROLLER_ASSERT_SVH
`define CODE_LOCK_STEPPER_DOOR_CONTROLLER_ASSERT_SVH

// Checked only while out of reset
`define CLSDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define CLSDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/clsdc_pkg.sv */
// Package for the code lock / stepper door controller: item types, state
// encodings, request codes, key codes and coil tables. No dependencies.
package clsdc_pkg;

    // One input item (one timer tick)
    typedef struct packed {
        logic [7:0] key_code;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [7:0] led_pattern;
        logic [3:0] coil_pattern;
        logic       tx_valid;
        logic [2:0] tx_byte;
        logic [7:0] echo_byte;
    } t_out_item;

    typedef enum logic [2:0] {
        LK_INIT  = 3'd0,
        LK_WAIT  = 3'd1,
        LK_HASH  = 3'd2,
        LK_ONE   = 3'd3,
        LK_TWO   = 3'd4,
        LK_THREE = 3'd5,
        LK_DONE  = 3'd6
    } t_lock_state;

    typedef enum logic [1:0] {
        DR_INIT  = 2'd0,
        DR_WAIT  = 2'd1,
        DR_OPEN  = 2'd2,
        DR_CLOSE = 2'd3
    } t_door_state;

    // Door request flag codes
    localparam logic [2:0] REQ_IDLE   = 3'd0;
    localparam logic [2:0] REQ_OPEN   = 3'd1;
    localparam logic [2:0] REQ_OPENED = 3'd3;
    localparam logic [2:0] REQ_CLOSE  = 3'd4;

    // Serial command bytes
    localparam logic [7:0] CMD_OPEN  = 8'h01;
    localparam logic [7:0] CMD_CLOSE = 8'h04;

    // Key codes (ASCII)
    localparam logic [7:0] KEY_NONE  = 8'h00;
    localparam logic [7:0] KEY_HASH  = 8'h23;
    localparam logic [7:0] KEY_ONE   = 8'h31;
    localparam logic [7:0] KEY_TWO   = 8'h32;
    localparam logic [7:0] KEY_THREE = 8'h33;
    localparam logic [7:0] KEY_A     = 8'h41;

    // LED patterns
    localparam logic [7:0] LED_OFF  = 8'h00;
    localparam logic [7:0] LED_P1   = 8'h01;
    localparam logic [7:0] LED_P2   = 8'h02;
    localparam logic [7:0] LED_P3   = 8'h04;
    localparam logic [7:0] LED_P4   = 8'h08;
    localparam logic [7:0] LED_P5   = 8'h10;
    localparam logic [7:0] LED_FULL = 8'hFF;

    localparam logic [15:0] TRAVEL_RESET = 16'd4096;
    localparam logic [3:0]  PHASE_COUNT  = 4'd8;

    // Lock machine result handed to the door stage
    typedef struct packed {
        t_lock_state state;
        logic [7:0]  led;
        logic [2:0]  req;
    } t_lock_out;

    // Door machine registers
    typedef struct packed {
        t_door_state state;
        logic [3:0]  phase;
        logic [15:0] steps;
        logic [3:0]  coil;
    } t_door_regs;

    // Half-step coil table, opening direction
    function automatic logic [3:0] open_coil(input logic [2:0] idx);
        logic [3:0] c;
        unique case (idx)
            3'd0: c = 4'h1;
            3'd1: c = 4'h3;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'hC;
            3'd6: c = 4'h8;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    // Half-step coil table, closing direction
    function automatic logic [3:0] close_coil(input logic [2:0] idx);
        logic [3:0] c;
        unique case (idx)
            3'd0: c = 4'h8;
            3'd1: c = 4'hC;
            3'd2: c = 4'h4;
            3'd3: c = 4'h6;
            3'd4: c = 4'h2;
            3'd5: c = 4'h3;
            3'd6: c = 4'h1;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/code_lock_stepper_door_controller.sv */
// Top level of the code lock / stepper door controller.
// Depends on clsdc_pkg, clsdc_lock and clsdc_door.
//
// Usage:
//   Input channel (i_valid / o_ready / i_item): one item per timer tick, with
//   the pressed key, an optional received serial byte and the tx ready bit.
//   Output channel (o_valid / i_ready / o_item): exactly one result per item,
//   in order: LED port, coil bits, tx flag and byte, echoed command byte.
//   Config: i_cfg_we writes i_cfg_wdata into the travel length (half-steps)
//   at the clock edge; write only while the block is idle.
// Timing:
//   An item is captured in the input register; the lock, door and serial
//   stages are combinational, and block state and result register load together.
//   o_valid rises once the result register is loaded; while i_ready stays
//   high, one item per cycle is sustained.
// Reset (i_rst_n low, synchronous): both stages empty, all state cleared,
//   travel length back to 4096 half-steps.
// Stall: while i_ready is low the result holds; one more item waits in the
//   input register, then o_ready drops until the result is taken.
module code_lock_stepper_door_controller
    import clsdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_travel;

    logic [7:0]  r_held_key;
    t_lock_state r_lock_state;
    logic [2:0]  r_req;
    t_door_regs  r_door;
    logic [7:0]  r_kept;
    logic [7:0]  r_led;

    logic [7:0]  n_held_key;
    t_lock_out   lock_res;
    t_door_regs  n_door;
    logic [2:0]  door_req;
    logic [7:0]  n_led;
    logic [7:0]  rx_kept;
    logic [7:0]  n_kept;
    logic [2:0]  n_req;
    t_out_item   n_out_item;
    logic        fire;

    // Handshake: process when an item waits and the result slot frees up
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // Key latch
    assign n_held_key = (r_in_item.key_code != KEY_NONE) ? r_in_item.key_code : r_held_key;

    clsdc_lock u_lock (
        .i_held_key (n_held_key),
        .i_state    (r_lock_state),
        .i_led      (r_led),
        .i_req      (r_req),
        .o_lock     (lock_res)
    );

    clsdc_door u_door (
        .i_door         (r_door),
        .i_req          (lock_res.req),
        .i_led          (lock_res.led),
        .i_travel_steps (r_travel),
        .o_door         (n_door),
        .o_req          (door_req),
        .o_led          (n_led)
    );

    // Serial command stage: a kept 1 or 4 forces the request every tick
    assign rx_kept = r_in_item.rx_valid ? r_in_item.rx_byte : r_kept;
    always_comb begin
        n_kept = rx_kept;
        n_req  = door_req;
        if (rx_kept == CMD_OPEN) begin
            n_req = REQ_OPEN;
        end else if (rx_kept == CMD_CLOSE) begin
            n_req = REQ_CLOSE;
        end else begin
            n_kept = 8'd0;
        end
    end

    // Result item
    always_comb begin
        n_out_item.led_pattern  = n_led;
        n_out_item.coil_pattern = n_door.coil;
        n_out_item.tx_valid     = r_in_item.tx_ready;
        n_out_item.tx_byte      = r_in_item.tx_ready ? n_req : REQ_IDLE;
        n_out_item.echo_byte    = n_kept;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    // Block state, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key   <= 8'd0;
            r_lock_state <= LK_INIT;
            r_req        <= REQ_IDLE;
            r_door       <= '{state: DR_INIT, phase: 4'd0, steps: 16'd0, coil: 4'd0};
            r_kept       <= 8'd0;
            r_led        <= LED_OFF;
        end else if (fire) begin
            r_held_key   <= n_held_key;
            r_lock_state <= lock_res.state;
            r_req        <= n_req;
            r_door       <= n_door;
            r_kept       <= n_kept;
            r_led        <= n_led;
        end
    end

    // Travel length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel <= TRAVEL_RESET;
        end else if (i_cfg_we) begin
            r_travel <= i_cfg_wdata;
        end
    end

endmodule

/* hw/rtl/clsdc_lock.sv */
// Lock machine: follows the key sequence #,1,2,3,A and toggles the door request.
// Combinational; depends on clsdc_pkg.
module clsdc_lock
    import clsdc_pkg::*;
(
    input  logic [7:0]  i_held_key,
    input  t_lock_state i_state,
    input  logic [7:0]  i_led,
    input  logic [2:0]  i_req,
    output t_lock_out   o_lock
);

    logic [7:0]  want;
    logic [7:0]  prev_key;
    t_lock_state next_state;
    logic [7:0]  step_led;

    // Per-stage expected key, key that keeps the stage, and LED pattern
    always_comb begin
        want       = KEY_ONE;
        prev_key   = KEY_HASH;
        next_state = LK_ONE;
        step_led   = LED_P2;
        unique case (i_state)
            LK_ONE: begin
                want = KEY_TWO;   prev_key = KEY_ONE;   next_state = LK_TWO;   step_led = LED_P3;
            end
            LK_TWO: begin
                want = KEY_THREE; prev_key = KEY_TWO;   next_state = LK_THREE; step_led = LED_P4;
            end
            LK_THREE: begin
                want = KEY_A;     prev_key = KEY_THREE; next_state = LK_DONE;  step_led = LED_P5;
            end
            default: ;
        endcase
    end

    // Next lock state, LED and request
    always_comb begin
        o_lock = '{state: i_state, led: i_led, req: i_req};
        unique case (i_state)
            LK_INIT: o_lock.state = LK_WAIT;
            LK_WAIT: begin
                if (i_held_key == KEY_HASH) begin
                    o_lock.state = LK_HASH;
                    o_lock.led   = LED_P1;
                end else begin
                    o_lock.led = LED_OFF;
                end
            end
            LK_HASH, LK_ONE, LK_TWO, LK_THREE: begin
                // holding the previous key keeps the stage
                if (i_held_key != prev_key) begin
                    if (i_held_key == want) begin
                        o_lock.state = next_state;
                        o_lock.led   = step_led;
                    end else begin
                        o_lock.state = LK_WAIT;
                        o_lock.led   = LED_OFF;
                    end
                end
            end
            LK_DONE: begin
                if (i_req == REQ_IDLE) begin
                    o_lock.led = LED_FULL;
                    o_lock.req = REQ_OPEN;
                end else if (i_req == REQ_OPENED) begin
                    o_lock.led = LED_FULL;
                    o_lock.req = REQ_CLOSE;
                end
                o_lock.state = LK_WAIT;
            end
            default: o_lock.state = LK_INIT;
        endcase
    end

endmodule

/* hw/rtl/clsdc_door.sv */
// Door machine: takes open/close requests and steps the motor through the
// half-step coil tables. Combinational; depends on clsdc_pkg.
module clsdc_door
    import clsdc_pkg::*;
(
    input  t_door_regs  i_door,
    input  logic [2:0]  i_req,
    input  logic [7:0]  i_led,
    input  logic [15:0] i_travel_steps,
    output t_door_regs  o_door,
    output logic [2:0]  o_req,
    output logic [7:0]  o_led
);

    logic [3:0] phase_wrap;
    logic [3:0] coil_next;

    // Phase index wraps back to zero past the table end
    assign phase_wrap = (i_door.phase >= PHASE_COUNT) ? 4'd0 : i_door.phase;
    assign coil_next  = (i_door.state == DR_OPEN) ? open_coil(phase_wrap[2:0])
                                                  : close_coil(phase_wrap[2:0]);

    always_comb begin
        o_door = i_door;
        o_req  = i_req;
        o_led  = i_led;
        unique case (i_door.state)
            DR_INIT: o_door.state = DR_WAIT;
            DR_WAIT: begin
                if (i_req == REQ_OPEN) begin
                    o_req        = REQ_OPENED;
                    o_led        = LED_P1;
                    o_door.state = DR_OPEN;
                end else if (i_req == REQ_CLOSE) begin
                    o_req        = REQ_IDLE;
                    o_door.state = DR_CLOSE;
                end else begin
                    // idle door blanks the indicators
                    o_led = LED_OFF;
                end
            end
            DR_OPEN, DR_CLOSE: begin
                if (i_door.steps < i_travel_steps) begin
                    o_door.coil  = coil_next;
                    o_door.phase = phase_wrap + 4'd1;
                    o_door.steps = i_door.steps + 16'd1;
                end else begin
                    o_door.phase = 4'd0;
                    o_door.steps = 16'd0;
                    o_door.state = DR_WAIT;
                end
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/clsdc_checker.sv */
// Port-level checker for the code lock controller, bound to the top level.
// Depends on clsdc_pkg and code_lock_stepper_door_controller_assert.svh.
`include "code_lock_stepper_door_controller_assert.svh"

module clsdc_checker
    import clsdc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input t_out_item   o_item
);

    // A stalled result item holds its value
    `CLSDC_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_item), "result changed while stalled")

    // No result straight out of reset
    `CLSDC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid, "result valid after reset")

    // Flag byte is zero whenever it is not sent
    `CLSDC_ASSERT(a_tx_quiet, o_valid && !o_item.tx_valid |-> o_item.tx_byte == REQ_IDLE, "tx byte set while not sent")

    // Sent flag is always a defined request code
    `CLSDC_ASSERT(a_tx_code, o_valid && o_item.tx_valid |-> o_item.tx_byte == REQ_IDLE || o_item.tx_byte == REQ_OPEN || o_item.tx_byte == REQ_OPENED || o_item.tx_byte == REQ_CLOSE, "bad request code")

    // Echo is zero or a known command
    `CLSDC_ASSERT(a_echo_cmd, o_valid |-> o_item.echo_byte == 8'd0 || o_item.echo_byte == CMD_OPEN || o_item.echo_byte == CMD_CLOSE, "bad echo byte")

endmodule

bind code_lock_stepper_door_controller clsdc_checker u_clsdc_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for code_lock_stepper_door_controller: random and
// directed timer ticks, an in-bench tick predictor and an in-order result check.
// Depends on clsdc_pkg and the RTL of the block only.
module tb_top;
    import clsdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    // Half-step coil tables, entry 0 in the low nibble
    localparam logic [31:0] OPEN_COILS  = 32'h98C46231;
    localparam logic [31:0] CLOSE_COILS = 32'h913264C8;
    // Unlock code, first key in the low byte
    localparam logic [39:0] DOOR_CODE   = {KEY_A, KEY_THREE, KEY_TWO, KEY_ONE, KEY_HASH};

    typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HALF, SINK_THIRD} t_sink_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_item;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    code_lock_stepper_door_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Ticks waiting to be sent, and predicted results waiting to come out
    t_in_item  pending_ticks[$];
    t_out_item predicted_outs[$];
    int        err_count;
    int        checked_count;
    int        cycle_count;

    // Predictor state
    logic [7:0]  held_key;
    t_lock_state lock_st;
    logic [2:0]  door_req;
    t_door_state door_st;
    logic [3:0]  phase_idx;
    logic [15:0] step_cnt;
    logic [7:0]  kept_cmd;
    logic [7:0]  led_val;
    logic [3:0]  coil_val;
    logic [15:0] travel_len;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // One code digit: holding the previous key waits, a wrong key starts over
    function automatic void code_digit(logic [7:0] want, logic [7:0] prev_key,
                                       t_lock_state next_st, logic [7:0] leds);
        if (held_key == prev_key)
            return;
        if (held_key == want) begin
            led_val = leds;
            lock_st = next_st;
        end else begin
            lock_st = LK_WAIT;
            led_val = LED_OFF;
        end
    endfunction

    // One half-step of door travel, or end of travel
    function automatic void door_half_step(logic opening);
        if (step_cnt < travel_len) begin
            if (phase_idx >= PHASE_COUNT)
                phase_idx = 4'd0;
            coil_val  = opening ? OPEN_COILS[phase_idx[2:0]*4 +: 4]
                                : CLOSE_COILS[phase_idx[2:0]*4 +: 4];
            phase_idx = phase_idx + 4'd1;
            step_cnt  = step_cnt + 16'd1;
        end else begin
            phase_idx = 4'd0;
            step_cnt  = 16'd0;
            door_st   = DR_WAIT;
        end
    endfunction

    // Advance the predicted lock, door and serial state by one tick
    function automatic t_out_item door_lock_tick(t_in_item tick);
        t_out_item res;
        if (tick.key_code != KEY_NONE)
            held_key = tick.key_code;

        case (lock_st)
            LK_INIT: lock_st = LK_WAIT;
            LK_WAIT: begin
                if (held_key == KEY_HASH) begin
                    lock_st = LK_HASH;
                    led_val = LED_P1;
                end else begin
                    led_val = LED_OFF;
                end
            end
            LK_HASH:  code_digit(KEY_ONE, KEY_HASH, LK_ONE, LED_P2);
            LK_ONE:   code_digit(KEY_TWO, KEY_ONE, LK_TWO, LED_P3);
            LK_TWO:   code_digit(KEY_THREE, KEY_TWO, LK_THREE, LED_P4);
            LK_THREE: code_digit(KEY_A, KEY_THREE, LK_DONE, LED_P5);
            LK_DONE: begin
                if (door_req == REQ_IDLE) begin
                    led_val  = LED_FULL;
                    door_req = REQ_OPEN;
                end else if (door_req == REQ_OPENED) begin
                    led_val  = LED_FULL;
                    door_req = REQ_CLOSE;
                end
                lock_st = LK_WAIT;
            end
            default: lock_st = LK_INIT;
        endcase

        case (door_st)
            DR_INIT: door_st = DR_WAIT;
            DR_WAIT: begin
                if (door_req == REQ_OPEN) begin
                    door_req = REQ_OPENED;
                    led_val  = LED_P1;
                    door_st  = DR_OPEN;
                end else if (door_req == REQ_CLOSE) begin
                    door_req = REQ_IDLE;
                    door_st  = DR_CLOSE;
                end else begin
                    led_val = LED_OFF;
                end
            end
            DR_OPEN: door_half_step(1'b1);
            default: door_half_step(1'b0);
        endcase

        // Kept serial command forces the request every tick
        if (tick.rx_valid)
            kept_cmd = tick.rx_byte;
        if (kept_cmd == CMD_OPEN)
            door_req = REQ_OPEN;
        else if (kept_cmd == CMD_CLOSE)
            door_req = REQ_CLOSE;
        else
            kept_cmd = 8'h00;

        res.led_pattern  = led_val;
        res.coil_pattern = coil_val;
        res.tx_valid     = tick.tx_ready;
        res.tx_byte      = tick.tx_ready ? door_req : REQ_IDLE;
        res.echo_byte    = kept_cmd;
        return res;
    endfunction

    task automatic add_tick(logic [7:0] key, logic rx_v, logic [7:0] rx_b, logic tx_r);
        t_in_item tick;
        tick.key_code = key;
        tick.rx_valid = rx_v;
        tick.rx_byte  = rx_b;
        tick.tx_ready = tx_r;
        pending_ticks.push_back(tick);
    endtask

    // Tick with the given key and random serial fields; commands are common
    task automatic add_key_tick(logic [7:0] key);
        logic [7:0] rx_b;
        int         pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            rx_b = CMD_OPEN;
        else if (pick == 1)
            rx_b = CMD_CLOSE;
        else
            rx_b = 8'($urandom_range(0, 255));
        add_tick(key, $urandom_range(0, 11) == 0, rx_b, 1'($urandom_range(0, 1)));
    endtask

    // Code entry with held keys and blank ticks, sometimes one wrong key
    task automatic add_code_entry();
        int         bad_pos;
        logic [7:0] key;
        bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 5;
        for (int i = 0; i < 5; i++) begin
            key = (i == bad_pos) ? 8'($urandom_range(1, 255)) : DOOR_CODE[i*8 +: 8];
            repeat ($urandom_range(1, 3)) add_key_tick(key);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) add_key_tick(KEY_NONE);
        end
        repeat ($urandom_range(1, 8)) add_key_tick(KEY_NONE);
    endtask

    task automatic add_random_ticks(int target);
        int pick;
        while (pending_ticks.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                add_code_entry();
            else if (pick <= 7)
                repeat ($urandom_range(1, 6)) add_key_tick(8'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 10)) add_key_tick(KEY_NONE);
        end
    endtask

    // Directed ticks: reset path, open and close by code, wrong key, commands
    task automatic add_directed_ticks();
        add_tick(KEY_NONE, 1'b0, 8'h00, 1'b0);
        add_tick(KEY_NONE, 1'b0, 8'hFF, 1'b1);
        add_tick(KEY_HASH, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_HASH, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_ONE, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_TWO, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_THREE, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_A, 1'b0, 8'h00, 1'b1);
        repeat (5) add_tick(KEY_NONE, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_HASH, 1'b0, 8'h00, 1'b1);
        add_tick(8'h35, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_HASH, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_ONE, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_TWO, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_THREE, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_A, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_NONE, 1'b0, 8'h00, 1'b1);
        add_tick(KEY_NONE, 1'b1, CMD_OPEN, 1'b1);
        add_tick(8'hFF, 1'b1, 8'hFF, 1'b1);
        add_tick(KEY_NONE, 1'b1, CMD_CLOSE, 1'b0);
        add_tick(KEY_NONE, 1'b1, 8'h00, 1'b1);
    endtask

    // Wait until no tick is queued, in flight or owed a result
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_valid || predicted_outs.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Stimulus: phases with different travel lengths, config written while drained
    initial begin
        logic [15:0] travel_cfg;
        int          target;
        err_count     = 0;
        checked_count = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 16'd0;
        held_key      = KEY_NONE;
        lock_st       = LK_INIT;
        door_req      = REQ_IDLE;
        door_st       = DR_INIT;
        phase_idx     = 4'd0;
        step_cnt      = 16'd0;
        kept_cmd      = 8'h00;
        led_val       = LED_OFF;
        coil_val      = 4'h0;
        travel_len    = TRAVEL_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: travel_cfg = 16'd3;
                    2: travel_cfg = 16'd0;
                    3: travel_cfg = 16'd1;
                    4: travel_cfg = 16'hFFFF;
                    5: travel_cfg = 16'd2;
                    default: travel_cfg = ($urandom_range(0, 3) == 0) ?
                                          16'($urandom_range(25, 400)) :
                                          16'($urandom_range(1, 24));
                endcase
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= travel_cfg;
                @(posedge i_clk);
                i_cfg_we   <= 1'b0;
                travel_len  = travel_cfg;
            end
            if (p == 1)
                add_directed_ticks();
            target = (p == 0) ? 40 : (p == 4) ? 60 : 150 + pending_ticks.size();
            add_random_ticks(target);
        end

        wait_drained();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Driver: bursts of ticks with random gaps; predicts on each accepted item
    always @(posedge i_clk) begin : driver
        int burst_left;
        int gap_left;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_item     <= '0;
            burst_left  = 1;
            gap_left    = 0;
        end else begin
            if (i_valid && o_ready)
                predicted_outs.push_back(door_lock_tick(i_item));
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    i_item  <= pending_ticks.pop_front();
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern changes per window, plus one long hold-off
    always @(posedge i_clk) begin : receiver
        t_sink_mode sink_mode;
        int         window_left;
        int         hold_left;
        bit         hold_done;
        int         sink_cycle;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            sink_mode   = SINK_FREE;
            window_left = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
            sink_cycle  = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && checked_count >= 300) begin
            hold_done = 1'b1;
            hold_left = 250;
            i_ready  <= 1'b0;
        end else begin
            if (window_left == 0) begin
                sink_mode   = t_sink_mode'($urandom_range(0, 3));
                window_left = $urandom_range(8, 80);
            end else begin
                window_left--;
            end
            sink_cycle++;
            case (sink_mode)
                SINK_FREE:  i_ready <= 1'b1;
                SINK_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
                SINK_HALF:  i_ready <= 1'($urandom_range(0, 1));
                default:    i_ready <= (sink_cycle % 3 == 0);
            endcase
        end
    end

    // Monitor: every taken result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            checked_count++;
            if (predicted_outs.size() == 0) begin
                $error("result with no item outstanding: %p", o_item);
                err_count++;
            end else begin
                want = predicted_outs.pop_front();
                if (o_item.led_pattern !== want.led_pattern) begin
                    $error("led_pattern: expected %h, got %h",
                           want.led_pattern, o_item.led_pattern);
                    err_count++;
                end
                if (o_item.coil_pattern !== want.coil_pattern) begin
                    $error("coil_pattern: expected %h, got %h",
                           want.coil_pattern, o_item.coil_pattern);
                    err_count++;
                end
                if (o_item.tx_valid !== want.tx_valid) begin
                    $error("tx_valid: expected %b, got %b", want.tx_valid, o_item.tx_valid);
                    err_count++;
                end
                if (o_item.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %0d, got %0d", want.tx_byte, o_item.tx_byte);
                    err_count++;
                end
                if (o_item.echo_byte !== want.echo_byte) begin
                    $error("echo_byte: expected %h, got %h", want.echo_byte, o_item.echo_byte);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
